FILE: hw/rtl/dcdds_pkg.sv
// Shared sizes and the command format passed from front end to back end of the DDS player.
package dcdds_pkg;

    // TABLE_DEPTH must be a power of two.
    localparam int TABLE_DEPTH = 4096;
    localparam int NUM_TABLES  = 3;
    localparam int PHASE_BITS  = 32;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int TSEL_BITS   = 2;
    localparam int WORD_BITS   = 16;
    localparam int MEM_DEPTH   = NUM_TABLES * TABLE_DEPTH;
    localparam int MEM_ABITS   = TSEL_BITS + ADDR_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_LIT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [TSEL_BITS-1:0]   tsel;
        logic [ADDR_BITS-1:0]   addr;
        logic [WORD_BITS-1:0]   word;
        logic                   last;
    } cmd_t;

endpackage

FILE: hw/rtl/dual_channel_dds_waveform_player_unit.sv
// Top level of the dual-channel DDS waveform player.
// Words of a taken request pass the sequencer mask, queue, read stage and output register.
// Throughput: one DAC word per cycle while m_tready is high (the front-end sequencer issues
// one word command per cycle unless the queue is full); input waits for the last command.
// Reset: asynchronous, active low; clears phases, counts, queue and pipeline,
// sets config registers to defaults. Wave tables are not cleared.
module dual_channel_dds_waveform_player_unit
    import dcdds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // operation
    input  logic [63:0] s_tdata,   // table_select, table_index, table_word, cycle_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // dac_word
    output logic        m_tlast
);

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    dcdds_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    dcdds_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .valid    (q_valid),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd)
    );

    dcdds_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (pop_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: hw/rtl/dcdds_front.sv
// Front end: config registers, request decode, phase/count state and per-word command sequencer.
module dcdds_front
    import dcdds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,
    input  logic [63:0] s_tdata,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    typedef enum logic [1:0] {
        OP_TICK,
        OP_WRITE,
        OP_LOAD0,
        OP_LOAD1
    } op_t;

    typedef enum logic [2:0] {
        REG_MODE,
        REG_STEP0,
        REG_STEP1,
        REG_DC0,
        REG_DC1,
        REG_ZERO0,
        REG_ZERO1
    } cfg_reg_t;

    localparam int SLOT_PAIR_A = 0;
    localparam int SLOT_PAIR_B = 1;
    localparam int SLOT_CH0    = 2;
    localparam int SLOT_CH1    = 3;
    localparam int SLOT_ZERO0  = 4;
    localparam int SLOT_ZERO1  = 5;
    localparam int SLOT_CNT0   = 6;
    localparam int SLOT_CNT1   = 7;
    localparam int SLOT_WRITE  = 8;
    localparam int NUM_SLOTS   = 9;

    localparam logic [6:0]  MODE_RESET  = 7'd18;
    localparam logic [15:0] ZERO0_RESET = 16'd14324;
    localparam logic [15:0] ZERO1_RESET = 16'd47112;

    localparam logic [TSEL_BITS-1:0] TAB_CH0  = TSEL_BITS'(0);
    localparam logic [TSEL_BITS-1:0] TAB_CH1  = TSEL_BITS'(1);
    localparam logic [TSEL_BITS-1:0] TAB_DIFF = TSEL_BITS'(2);

    logic [6:0]            mode_reg;
    logic [31:0]           step0_reg;
    logic [31:0]           step1_reg;
    logic [15:0]           dc0_reg;
    logic [15:0]           dc1_reg;
    logic [15:0]           zero0_reg;
    logic [15:0]           zero1_reg;

    logic [PHASE_BITS-1:0] ph0_reg, ph0_next;
    logic [PHASE_BITS-1:0] ph1_reg, ph1_next;
    logic [31:0]           cnt0_reg, cnt0_next;
    logic [31:0]           cnt1_reg, cnt1_next;
    logic [NUM_SLOTS-1:0]  mask_reg, mask_next;
    logic [TSEL_BITS-1:0]  wr_sel_reg;
    logic [ADDR_BITS-1:0]  wr_idx_reg;
    logic [WORD_BITS-1:0]  wr_word_reg;

    logic [NUM_SLOTS-1:0]  low;
    logic [NUM_SLOTS-1:0]  rest;
    logic [NUM_SLOTS-1:0]  tick_mask;
    logic [PHASE_BITS-1:0] add0;
    logic [PHASE_BITS-1:0] add1;
    logic                  busy;
    logic                  accept;
    logic                  run0, dc0, cyc0, run1, dc1, cyc1, pair;
    op_t                   op;
    logic [TSEL_BITS-1:0]  in_sel;
    logic [11:0]           in_idx;
    logic [WORD_BITS-1:0]  in_word;
    logic [31:0]           in_count;

    assign op       = op_t'(s_tuser);
    assign in_sel   = s_tdata[1:0];
    assign in_idx   = s_tdata[13:2];
    assign in_word  = s_tdata[29:14];
    assign in_count = s_tdata[61:30];

    assign run0 = mode_reg[0];
    assign dc0  = mode_reg[1];
    assign cyc0 = mode_reg[2];
    assign run1 = mode_reg[3];
    assign dc1  = mode_reg[4];
    assign cyc1 = mode_reg[5];
    assign pair = mode_reg[6];

    always_comb
    begin
        low      = mask_reg & (~mask_reg + NUM_SLOTS'(1));
        rest     = mask_reg & ~low;
        busy     = |mask_reg;
        q_push   = busy && !q_full;
        s_tready = !busy || (!(|rest) && !q_full);
        accept   = s_tvalid && s_tready;
        add0     = ph0_reg + PHASE_BITS'(step0_reg);
        add1     = ph1_reg + PHASE_BITS'(step1_reg);

        tick_mask              = '0;
        tick_mask[SLOT_PAIR_A] = run0 && pair;
        tick_mask[SLOT_PAIR_B] = run0 && pair;
        tick_mask[SLOT_CH0]    = run0 && !pair && (dc0 || !cyc0);
        tick_mask[SLOT_CH1]    = run1 && !pair && (dc1 || !cyc1);
        tick_mask[SLOT_ZERO0]  = !run0 && !run1;
        tick_mask[SLOT_ZERO1]  = !run0 && !run1;
        tick_mask[SLOT_CNT0]   = cyc0 && run0;
        tick_mask[SLOT_CNT1]   = cyc1 && run1;

        ph0_next  = ph0_reg;
        ph1_next  = ph1_reg;
        cnt0_next = cnt0_reg;
        cnt1_next = cnt1_reg;
        mask_next = mask_reg;

        q_cmd.kind = CMD_LIT;
        q_cmd.tsel = TAB_CH0;
        q_cmd.addr = add0[PHASE_BITS-1 -: ADDR_BITS];
        q_cmd.word = '0;
        q_cmd.last = !(|rest);

        if (low[SLOT_PAIR_A])
        begin
            q_cmd.kind = CMD_READ;
            ph0_next   = add0;
        end
        else if (low[SLOT_PAIR_B])
        begin
            q_cmd.kind = CMD_READ;
            q_cmd.tsel = TAB_DIFF;
            q_cmd.addr = ph0_reg[PHASE_BITS-1 -: ADDR_BITS];
        end
        else if (low[SLOT_CH0])
        begin
            if (!dc0 && !cyc0)
            begin
                q_cmd.kind = CMD_READ;
                ph0_next   = add0;
            end
            else
            begin
                q_cmd.word = dc0_reg;
            end
        end
        else if (low[SLOT_CH1])
        begin
            q_cmd.tsel = TAB_CH1;
            q_cmd.addr = add1[PHASE_BITS-1 -: ADDR_BITS];
            if (!dc1 && !cyc1)
            begin
                q_cmd.kind = CMD_READ;
                ph1_next   = add1;
            end
            else
            begin
                q_cmd.word = dc1_reg;
            end
        end
        else if (low[SLOT_ZERO0])
        begin
            q_cmd.word = zero0_reg;
        end
        else if (low[SLOT_ZERO1])
        begin
            q_cmd.word = zero1_reg;
        end
        else if (low[SLOT_CNT0])
        begin
            if (cnt0_reg != '0)
            begin
                q_cmd.kind = CMD_READ;
                ph0_next   = add0;
                cnt0_next  = cnt0_reg - 32'd1;
            end
            else
            begin
                q_cmd.word = zero0_reg;
            end
        end
        else if (low[SLOT_CNT1])
        begin
            q_cmd.tsel = TAB_CH1;
            q_cmd.addr = add1[PHASE_BITS-1 -: ADDR_BITS];
            if (cnt1_reg != '0)
            begin
                q_cmd.kind = CMD_READ;
                ph1_next   = add1;
                cnt1_next  = cnt1_reg - 32'd1;
            end
            else
            begin
                q_cmd.word = zero1_reg;
            end
        end
        else
        begin
            q_cmd.kind = CMD_WRITE;
            q_cmd.tsel = wr_sel_reg;
            q_cmd.addr = wr_idx_reg;
            q_cmd.word = wr_word_reg;
        end

        if (!q_push)
        begin
            ph0_next  = ph0_reg;
            ph1_next  = ph1_reg;
            cnt0_next = cnt0_reg;
            cnt1_next = cnt1_reg;
        end
        else
        begin
            mask_next = rest;
        end

        // new request overrides; a count load wins over a final decrement
        if (accept)
        begin
            case (op)
                OP_TICK:
                begin
                    mask_next = tick_mask;
                end
                OP_WRITE:
                begin
                    mask_next             = '0;
                    mask_next[SLOT_WRITE] = (32'(in_sel) < 32'(NUM_TABLES));
                end
                OP_LOAD0:
                begin
                    mask_next = '0;
                    cnt0_next = in_count;
                end
                OP_LOAD1:
                begin
                    mask_next = '0;
                    cnt1_next = in_count;
                end
                default:
                begin
                    mask_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            step0_reg <= '0;
            step1_reg <= '0;
            dc0_reg   <= '0;
            dc1_reg   <= '0;
            zero0_reg <= ZERO0_RESET;
            zero1_reg <= ZERO1_RESET;
            ph0_reg   <= '0;
            ph1_reg   <= '0;
            cnt0_reg  <= '0;
            cnt1_reg  <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            ph0_reg  <= ph0_next;
            ph1_reg  <= ph1_next;
            cnt0_reg <= cnt0_next;
            cnt1_reg <= cnt1_next;
            mask_reg <= mask_next;
            if (cfg_wen)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_MODE:  mode_reg  <= cfg_data[6:0];
                    REG_STEP0: step0_reg <= cfg_data;
                    REG_STEP1: step1_reg <= cfg_data;
                    REG_DC0:   dc0_reg   <= cfg_data[15:0];
                    REG_DC1:   dc1_reg   <= cfg_data[15:0];
                    REG_ZERO0: zero0_reg <= cfg_data[15:0];
                    REG_ZERO1: zero1_reg <= cfg_data[15:0];
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wr_sel_reg  <= in_sel;
            wr_idx_reg  <= ADDR_BITS'(in_idx);
            wr_word_reg <= in_word;
        end
    end

endmodule

FILE: hw/rtl/dcdds_queue.sv
// Short command queue between front end and back end.
module dcdds_queue
    import dcdds_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic valid,
    input  logic pop,
    output cmd_t pop_cmd
);

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;

    assign full    = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_BITS+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hw/rtl/dcdds_back.sv
// Back end: wave table memory, table read stage and output register.
module dcdds_back
    import dcdds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_pop,
    input  cmd_t        q_cmd,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    logic [WORD_BITS-1:0] mem [MEM_DEPTH];

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_lit_reg;
    logic [WORD_BITS-1:0] s1_word_reg;
    logic                 s1_last_reg;
    logic [WORD_BITS-1:0] rd_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [WORD_BITS-1:0] m_data_reg;
    logic                 m_last_reg;

    logic                 out_free;
    logic                 s1_move;
    logic                 s1_free;
    logic                 pop_out;
    logic [MEM_ABITS-1:0] mem_addr;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign mem_addr = {q_cmd.tsel, q_cmd.addr};

    always_comb
    begin
        out_free = !m_valid_reg || m_tready;
        s1_move  = s1_valid_reg && out_free;
        s1_free  = !s1_valid_reg || s1_move;
        q_pop    = q_valid && s1_free;
        pop_out  = q_pop && (q_cmd.kind != CMD_WRITE);

        s1_valid_next = s1_valid_reg;
        if (q_pop)
        begin
            s1_valid_next = pop_out;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (s1_move)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            case (q_cmd.kind)
                CMD_WRITE: mem[mem_addr] <= q_cmd.word;
                CMD_READ:  rd_reg <= mem[mem_addr];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_out)
        begin
            s1_lit_reg  <= (q_cmd.kind == CMD_LIT);
            s1_word_reg <= q_cmd.word;
            s1_last_reg <= q_cmd.last;
        end
        if (s1_move)
        begin
            m_data_reg <= s1_lit_reg ? s1_word_reg : rd_reg;
            m_last_reg <= s1_last_reg;
        end
    end

endmodule

FILE: dv/dual_channel_dds_waveform_player_unit_test.sv
// Stream testbench for the dual-channel DDS waveform player: directed mode tests plus random traffic.
module dual_channel_dds_waveform_player_unit_test;
    import dcdds_pkg::*;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_TABLE_WRITE,
        OP_LOAD_CH0,
        OP_LOAD_CH1
    } dds_op_t;

    typedef enum logic [2:0] {
        REG_MODE,
        REG_CH0_STEP,
        REG_CH1_STEP,
        REG_CH0_DC,
        REG_CH1_DC,
        REG_CH0_ZERO,
        REG_CH1_ZERO
    } reg_index_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 last;
    } dac_sample_t;

    localparam logic [6:0] RUN0   = 7'h01;
    localparam logic [6:0] DC0    = 7'h02;
    localparam logic [6:0] CYC0   = 7'h04;
    localparam logic [6:0] RUN1   = 7'h08;
    localparam logic [6:0] DC1    = 7'h10;
    localparam logic [6:0] CYC1   = 7'h20;
    localparam logic [6:0] PAIRED = 7'h40;

    localparam int WAVE_CH0  = 0;
    localparam int WAVE_CH1  = 1;
    localparam int WAVE_DIFF = 2;
    localparam int BAD_TABLE = 3;

    // s_tdata layout
    localparam int TSEL_LSB  = 0;
    localparam int INDEX_LSB = 2;
    localparam int WORD_LSB  = 14;
    localparam int COUNT_LSB = 30;

    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int MAX_PRINTS    = 100;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wen;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;   // operation
    logic [63:0] s_tdata;   // table_select, table_index, table_word, cycle_count
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // dac_word
    logic        m_tlast;   // last

    dual_channel_dds_waveform_player_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Predicted block state
    logic [6:0]            mode_reg   = 7'd18;
    logic [31:0]           step0      = '0;
    logic [31:0]           step1      = '0;
    logic [WORD_BITS-1:0]  dc0_word   = '0;
    logic [WORD_BITS-1:0]  dc1_word   = '0;
    logic [WORD_BITS-1:0]  zero0_word = 16'd14324;
    logic [WORD_BITS-1:0]  zero1_word = 16'd47112;
    logic [PHASE_BITS-1:0] phase0     = '0;
    logic [PHASE_BITS-1:0] phase1     = '0;
    logic [31:0]           cycles0    = '0;
    logic [31:0]           cycles1    = '0;
    logic [WORD_BITS-1:0]  wave_mem [MEM_DEPTH];
    bit                    wave_set [MEM_DEPTH];
    int                    tick_reads[$];

    dac_sample_t dac_expected[$];
    int          error_count    = 0;
    int          send_idle_pct  = 10;
    int          recv_idle_pct  = 72;
    int          settings_done  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin : check_dac
        dac_sample_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (dac_expected.size() == 0)
                report_mismatch($sformatf("unexpected DAC word %h", m_tdata));
            else
            begin
                want = dac_expected.pop_front();
                if (m_tdata !== want.word)
                    report_mismatch($sformatf("dac_word %h, expected %h", m_tdata, want.word));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %b, expected %b (word %h)",
                                              m_tlast, want.last, want.word));
            end
        end
    end

    function automatic logic [63:0] pack_request(input logic [31:0] sel, input logic [31:0] idx,
                                                 input logic [31:0] word, input logic [31:0] count);
        return {2'b00, count, word[15:0], idx[11:0], sel[1:0]};
    endfunction

    function automatic logic [WORD_BITS-1:0] read_wave(input int tbl,
                                                       input logic [PHASE_BITS-1:0] phase);
        int slot;
        slot = tbl * TABLE_DEPTH + int'(phase[PHASE_BITS-1 -: ADDR_BITS]);
        tick_reads.push_back(slot);
        return wave_set[slot] ? wave_mem[slot] : '0;
    endfunction

    // Predicts the words of one tick; with apply clear it only collects table addresses.
    function automatic void play_tick(input bit apply);
        logic [PHASE_BITS-1:0] p0, p1;
        logic [31:0]           c0, c1;
        logic [WORD_BITS-1:0]  words[$];
        bit                    run0, dc0, cyc0, run1, dc1, cyc1, pair;
        dac_sample_t           s;
        p0 = phase0;
        p1 = phase1;
        c0 = cycles0;
        c1 = cycles1;
        tick_reads.delete();
        run0 = |(mode_reg & RUN0);
        dc0  = |(mode_reg & DC0);
        cyc0 = |(mode_reg & CYC0);
        run1 = |(mode_reg & RUN1);
        dc1  = |(mode_reg & DC1);
        cyc1 = |(mode_reg & CYC1);
        pair = |(mode_reg & PAIRED);
        if (run0 && pair)
        begin
            p0 += step0;
            words.push_back(read_wave(WAVE_CH0, p0));
            words.push_back(read_wave(WAVE_DIFF, p0));
        end
        if (run0 && !pair)
        begin
            if (!dc0 && !cyc0)
            begin
                p0 += step0;
                words.push_back(read_wave(WAVE_CH0, p0));
            end
            else if (dc0)
                words.push_back(dc0_word);
        end
        if (run1 && !pair)
        begin
            if (!dc1 && !cyc1)
            begin
                p1 += step1;
                words.push_back(read_wave(WAVE_CH1, p1));
            end
            else if (dc1)
                words.push_back(dc1_word);
        end
        if (!run0 && !run1)
        begin
            words.push_back(zero0_word);
            words.push_back(zero1_word);
        end
        if (cyc0 && run0)
        begin
            if (c0 != 0)
            begin
                p0 += step0;
                words.push_back(read_wave(WAVE_CH0, p0));
                c0--;
            end
            else
                words.push_back(zero0_word);
        end
        if (cyc1 && run1)
        begin
            if (c1 != 0)
            begin
                p1 += step1;
                words.push_back(read_wave(WAVE_CH1, p1));
                c1--;
            end
            else
                words.push_back(zero1_word);
        end
        if (apply)
        begin
            phase0  = p0;
            phase1  = p1;
            cycles0 = c0;
            cycles1 = c1;
            foreach (words[i])
            begin
                s.word = words[i];
                s.last = (i == words.size() - 1);
                dac_expected.push_back(s);
            end
        end
    endfunction

    task automatic send_request(input dds_op_t op, input logic [63:0] data);
        logic [1:0] sel;
        int         slot;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        case (op)
            OP_TABLE_WRITE:
            begin
                sel = data[TSEL_LSB +: TSEL_BITS];
                if (int'(sel) < NUM_TABLES)
                begin
                    slot = int'(sel) * TABLE_DEPTH + int'(data[INDEX_LSB +: ADDR_BITS]);
                    wave_mem[slot] = data[WORD_LSB +: WORD_BITS];
                    wave_set[slot] = 1'b1;
                end
            end
            OP_LOAD_CH0: cycles0 = data[COUNT_LSB +: 32];
            OP_LOAD_CH1: cycles1 = data[COUNT_LSB +: 32];
            default:     play_tick(1'b1);
        endcase
    endtask

    // Fills any table entry the next tick would read before sending the tick.
    task automatic send_tick();
        int reads[$];
        play_tick(1'b0);
        reads = tick_reads;
        foreach (reads[i])
            if (!wave_set[reads[i]])
                send_request(OP_TABLE_WRITE, pack_request(reads[i] / TABLE_DEPTH,
                             reads[i] % TABLE_DEPTH, $urandom, $urandom));
        send_request(OP_TICK, pack_request($urandom, $urandom, $urandom, $urandom));
    endtask

    task automatic wait_for_drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (dac_expected.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (dac_expected.size() != 0)
        begin
            report_mismatch($sformatf("%0d DAC words never arrived", dac_expected.size()));
            dac_expected.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input reg_index_t idx, input logic [31:0] value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_MODE:     mode_reg   = value[6:0];
            REG_CH0_STEP: step0      = value;
            REG_CH1_STEP: step1      = value;
            REG_CH0_DC:   dc0_word   = value[15:0];
            REG_CH1_DC:   dc1_word   = value[15:0];
            REG_CH0_ZERO: zero0_word = value[15:0];
            default:      zero1_word = value[15:0];
        endcase
    endtask

    task automatic apply_settings(input logic [6:0] mode, input logic [31:0] s0,
                                  input logic [31:0] s1, input logic [15:0] d0,
                                  input logic [15:0] d1, input logic [15:0] z0,
                                  input logic [15:0] z1);
        wait_for_drain();
        write_register(REG_MODE, {25'd0, mode});
        write_register(REG_CH0_STEP, s0);
        write_register(REG_CH1_STEP, s1);
        write_register(REG_CH0_DC, {16'd0, d0});
        write_register(REG_CH1_DC, {16'd0, d1});
        write_register(REG_CH0_ZERO, {16'd0, z0});
        write_register(REG_CH1_ZERO, {16'd0, z1});
        cfg_wen <= 1'b0;
    endtask

    // Reset mode has both channels stopped: zero words only.
    task automatic test_reset_defaults();
        send_tick();
        send_request(OP_LOAD_CH0, pack_request(0, 0, 0, 32'hFFFF_FFFF));
        send_request(OP_LOAD_CH1, pack_request(0, 0, 0, 32'h0));
        send_tick();
    endtask

    task automatic test_table_writes();
        apply_settings(RUN0 | RUN1, 32'h0, 32'hFFF0_0000, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF);
        send_request(OP_TABLE_WRITE, pack_request(WAVE_CH0, 'h000, 'h0000, 0));
        send_request(OP_TABLE_WRITE, pack_request(WAVE_CH1, 'hFFF, 'hFFFF, 0));
        send_request(OP_TABLE_WRITE, pack_request(WAVE_DIFF, 'h000, 'hFFFF, 0));
        // bad select must not disturb entry 0 of any table
        send_request(OP_TABLE_WRITE, pack_request(BAD_TABLE, 'h000, 'h5A5A, 0));
        send_tick();
        send_tick();
    endtask

    task automatic test_paired_modes();
        apply_settings(RUN0 | CYC0 | RUN1 | CYC1 | PAIRED, 32'h0, 32'h0010_0000,
                       16'h1111, 16'h2222, 16'h3333, 16'h4444);
        send_request(OP_LOAD_CH0, pack_request(0, 0, 0, 32'd1));
        send_request(OP_LOAD_CH1, pack_request(0, 0, 0, 32'd1));
        send_tick();
        send_tick();
        // paired with channel 0 stopped gives no words
        apply_settings(RUN1 | PAIRED, 32'h0123_4567, 32'h89AB_CDEF,
                       16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0);
        send_tick();
        send_tick();
    endtask

    task automatic test_dc_with_counted();
        apply_settings(RUN0 | DC0 | CYC0 | RUN1 | DC1 | CYC1, 32'h8000_0000, 32'h0040_0000,
                       16'hFFFF, 16'h0000, 16'hABCD, 16'h1357);
        send_request(OP_LOAD_CH0, pack_request(0, 0, 0, 32'd2));
        send_request(OP_LOAD_CH1, pack_request(0, 0, 0, 32'd0));
        send_tick();
        send_tick();
        send_tick();
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        int          pick;
        logic [31:0] count;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int p = 0; p < 3; p++)
        begin
            if (settings_done == 0)
                apply_settings(7'h7F, '1, '1, '1, '1, '1, '1);
            else if (settings_done == 1)
                apply_settings(7'h00, '0, '0, '0, '0, '0, '0);
            else
                apply_settings(7'($urandom_range(127)),
                               ($urandom_range(3) == 0) ? $urandom_range(32'h0040_0000) : $urandom,
                               ($urandom_range(3) == 0) ? $urandom_range(32'h0040_0000) : $urandom,
                               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            settings_done++;
            repeat (10)
            begin
                pick  = $urandom_range(99);
                count = ($urandom_range(7) == 0) ? $urandom : $urandom_range(4);
                if (pick < 55)
                    send_tick();
                else if (pick < 75)
                    send_request(OP_TABLE_WRITE,
                                 pack_request($urandom_range(3), $urandom, $urandom, $urandom));
                else if (pick < 88)
                    send_request(OP_LOAD_CH0, pack_request($urandom, $urandom, $urandom, count));
                else
                    send_request(OP_LOAD_CH1, pack_request($urandom, $urandom, $urandom, count));
            end
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= '0;
        s_tdata   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_table_writes();
        test_paired_modes();
        test_dc_with_counted();
        test_random_traffic(10, 72);
        test_random_traffic(72, 10);
        test_random_traffic(0, 0);
        wait_for_drain();

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
